### design/matrix4_cofactor_inverse_top_assert.svh
// Assertion macros for the 4x4 inverse block.
`ifndef MATRIX4_COFACTOR_INVERSE_TOP_ASSERT_SVH
`define MATRIX4_COFACTOR_INVERSE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MCI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MCI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MCI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MCI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### design/mci_pkg.sv
package mci_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DET,
    ST_RCP_INIT,
    ST_RCP_NORM,
    ST_RCP_DIV,
    ST_COF,
    ST_SING
  } st_t;

  localparam logic [31:0] QBIT    = 32'h0040_0000;
  localparam logic [31:0] DEF_NAN = 32'hFFC0_0000;
  localparam logic [5:0]  DIV_STEPS = 6'd49;

  // column order of the six triple products, p0 in the low bits
  localparam logic [5:0] PERM [6] = '{
    6'b10_01_00, 6'b00_10_01, 6'b01_00_10,
    6'b00_01_10, 6'b01_10_00, 6'b10_00_01
  };

  // minor element indexes {w, z, y, x} of each det3 group
  localparam logic [15:0] PAIR [3] = '{16'h7584, 16'h8365, 16'h6473};

  function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
    return (n < x) ? n : 2'(n + 2'd1);
  endfunction

  function automatic logic [3:0] det_addr(input logic [1:0] j, input logic [4:0] s);
    logic [2:0] kk;
    logic [5:0] pm;
    logic [3:0] a;
    kk = s[4:2];
    a = 4'd0;
    if (s >= 5'd24) begin
      a = {2'd0, j};
    end else begin
      pm = PERM[kk];
      case (s[1:0])
        2'd0: a = {2'd1, skip(pm[1:0], j)};
        2'd1: a = {2'd2, skip(pm[3:2], j)};
        2'd2: a = {2'd3, skip(pm[5:4], j)};
        default: a = 4'd0;
      endcase
    end
    return a;
  endfunction

  function automatic logic [3:0] cof_addr(input logic [3:0] k, input logic [1:0] g,
                                          input logic [4:0] s);
    logic [15:0] pr;
    logic [3:0] n;
    logic [1:0] ri;
    logic [3:0] ci;
    pr = PAIR[g];
    case (s)
      5'd0: n = pr[3:0];
      5'd1: n = pr[7:4];
      5'd3: n = pr[11:8];
      5'd4: n = pr[15:12];
      5'd6: n = {2'd0, g};
      default: n = 4'd0;
    endcase
    ri = (n >= 4'd6) ? 2'd2 : (n >= 4'd3) ? 2'd1 : 2'd0;
    ci = 4'(n - 4'd3 * {2'd0, ri});
    return {skip(ri, k[1:0]), skip(ci[1:0], k[3:2])};
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

  // sig has bit 27 set; value is 1.sig * 2^(eb - 127)
  function automatic logic [31:0] pack_round(input logic sgn, input logic [27:0] sig,
                                             input logic signed [11:0] eb,
                                             input logic sticky);
    logic [27:0] sh;
    logic        st;
    logic [11:0] amt;
    logic [7:0]  ef;
    logic [30:0] field;
    logic        up;
    if (eb >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    if (eb <= 12'sd0) begin
      amt = 12'(12'sd1 - eb);
      if (amt >= 12'd28) begin
        sh = 28'd0;
        st = sticky | (|sig);
      end else begin
        sh = sig >> amt;
        st = sticky | (|(sig & ((28'd1 << amt) - 28'd1)));
      end
      ef = 8'd0;
    end else begin
      sh = sig;
      st = sticky;
      ef = 8'(eb - 12'sd1);
    end
    field = {ef, 23'd0} + {7'd0, sh[27:4]};
    st = st | (|sh[2:0]);
    up = sh[3] & (st | field[0]);
    return {sgn, 31'(field + 31'(up))};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sgn;
    logic [23:0] ma, mb;
    logic [7:0]  xa, xb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [11:0] e;
    sgn = a[31] ^ b[31];
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return a | QBIT;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return b | QBIT;
    if ((a[30:23] == 8'hFF && b[30:0] == 31'd0) || (b[30:23] == 8'hFF && a[30:0] == 31'd0))
      return DEF_NAN;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p = ma * mb;
    lz = lzc48(p);
    p = p << lz;
    e = 12'(xa) + 12'(xb) - 12'd126 - 12'(lz);
    return pack_round(sgn, p[47:20], e, |p[19:0]);
  endfunction

  function automatic logic [31:0] faddsub(input logic [31:0] a, input logic [31:0] b0,
                                          input logic sub);
    logic [31:0] b, big, sml;
    logic [23:0] mx, my;
    logic [7:0]  ex, ey, d;
    logic [26:0] xf, yf, y;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic signed [11:0] e;
    if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return a | QBIT;
    if (b0[30:23] == 8'hFF && b0[22:0] != 23'd0) return b0 | QBIT;
    b = {b0[31] ^ sub, b0[30:0]};
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return DEF_NAN;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    mx = {big[30:23] != 8'd0, big[22:0]};
    my = {sml[30:23] != 8'd0, sml[22:0]};
    ex = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    ey = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = 8'(ex - ey);
    xf = {mx, 3'd0};
    yf = {my, 3'd0};
    if (d >= 8'd27) y = {26'd0, |yf};
    else y = (yf >> d) | {26'd0, |(yf & ((27'd1 << d) - 27'd1))};
    if (big[31] == sml[31]) sum = {1'b0, xf} + {1'b0, y};
    else sum = {1'b0, xf} - {1'b0, y};
    if (sum == 28'd0) return 32'd0;
    lz = lzc28(sum);
    sum = sum << lz;
    e = 12'(ex) + 12'd1 - 12'(lz);
    return pack_round(big[31], sum, e, 1'b0);
  endfunction

endpackage

### design/matrix4_cofactor_inverse_top.sv
// Sequence: the 16 elements are loaded and the determinant is computed; if it is zero, 16
// zero words flagged singular follow, else its reciprocal is formed and 16 results follow.
// A new matrix waits until then. All work uses the one shared float multiplier
// and adder, the single read port of the matrix store and the bit-serial reciprocal.
// Reset: clears the state machine, element count and output valid; store is not cleared.
`include "matrix4_cofactor_inverse_top_assert.svh"
module matrix4_cofactor_inverse_top
  import mci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value_bits
  output logic [0:0]  m_tuser,   // [0] singular
  output logic        m_tlast
);

  st_t state, state_next;

  logic [31:0] mat_mem [16];
  logic [31:0] rdata;
  logic [3:0]  rd_addr;
  logic [3:0]  count;

  logic [1:0] j, j_next;
  logic [4:0] s, s_next;
  logic [3:0] k, k_next;
  logic [1:0] g, g_next;

  logic [31:0] acc_a, acc_b, acc_x, acc_d, acc_v, inv;
  logic [23:0] md, rem;
  logic signed [11:0] ed;
  logic [26:0] q;
  logic [5:0]  cnt;

  logic        in_fire, out_free, emit;
  logic [31:0] mul_l, mul_r, mul_res;
  logic [31:0] add_l, add_r, add_res;
  logic        add_sub;
  logic [2:0]  kk;
  logic [24:0] rsh;
  logic [27:0] qn;
  logic [4:0]  qlz;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign kk       = s[4:2];

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_fire && count == 4'd15) state_next = ST_DET;
      end
      ST_DET: begin
        if (j == 2'd3 && s == 5'd26) state_next = ST_RCP_INIT;
      end
      ST_RCP_INIT: begin
        if (acc_d[30:0] == 31'd0) state_next = ST_SING;
        else if (acc_d[30:23] == 8'hFF) state_next = ST_COF;
        else state_next = ST_RCP_NORM;
      end
      ST_RCP_NORM: begin
        if (md[23]) state_next = ST_RCP_DIV;
      end
      ST_RCP_DIV: begin
        if (cnt == DIV_STEPS) state_next = ST_COF;
      end
      ST_COF: begin
        if (s == 5'd8 && out_free && k == 4'd15) state_next = ST_LOAD;
      end
      ST_SING: begin
        if (out_free && k == 4'd15) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_LOAD);
    emit = ((state == ST_COF && s == 5'd8) || state == ST_SING) && out_free;
    j_next = j;
    s_next = s;
    k_next = k;
    g_next = g;
    case (state)
      ST_DET: begin
        if (s == 5'd26) begin
          s_next = 5'd0;
          j_next = 2'(j + 2'd1);
        end else begin
          s_next = 5'(s + 5'd1);
        end
      end
      ST_COF: begin
        if (s == 5'd8) begin
          if (out_free) begin
            s_next = 5'd0;
            g_next = 2'd0;
            k_next = 4'(k + 4'd1);
          end
        end else if (s == 5'd7 && g != 2'd2) begin
          s_next = 5'd0;
          g_next = 2'(g + 2'd1);
        end else begin
          s_next = 5'(s + 5'd1);
        end
      end
      ST_SING: begin
        if (out_free) k_next = 4'(k + 4'd1);
      end
      default: begin
        j_next = 2'd0;
        s_next = 5'd0;
        k_next = 4'd0;
        g_next = 2'd0;
      end
    endcase
    rd_addr = (state_next == ST_COF) ? cof_addr(k_next, g_next, s_next)
                                     : det_addr(j_next, s_next);
  end

  always_comb begin
    mul_l = acc_a;
    mul_r = rdata;
    add_l = acc_x;
    add_r = acc_a;
    add_sub = 1'b0;
    if (state == ST_DET) begin
      if (s == 5'd25) mul_r = acc_x;
      if (s == 5'd26) begin
        add_l = acc_d;
        add_sub = j[0];
      end else begin
        add_sub = (kk >= 3'd3);
      end
    end else begin
      if (s == 5'd6) begin
        mul_l = rdata;
        mul_r = acc_a;
      end else if (s == 5'd8) begin
        mul_l = {acc_v[31] ^ k[0] ^ k[2], acc_v[30:0]};
        mul_r = inv;
      end
      if (s == 5'd5) begin
        add_l = acc_b;
        add_sub = 1'b1;
      end else begin
        add_l = acc_v;
      end
    end
    mul_res = fmul(mul_l, mul_r);
    add_res = faddsub(add_l, add_r, add_sub);
    rsh = {rem, 1'b0};
    qlz = lzc28({1'b0, q});
    qn  = {1'b0, q} << qlz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= 4'd0;
      j        <= 2'd0;
      s        <= 5'd0;
      k        <= 4'd0;
      g        <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      s     <= s_next;
      k     <= k_next;
      g     <= g_next;
      if (in_fire) count <= 4'(count + 4'd1);
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) mat_mem[count] <= s_tdata;
    rdata <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_DET: begin
        if (s < 5'd24) begin
          case (s[1:0])
            2'd0: acc_a <= rdata;
            2'd3: acc_x <= (kk == 3'd0) ? acc_a : add_res;
            default: acc_a <= mul_res;
          endcase
        end else if (s == 5'd24) begin
          acc_a <= rdata;
        end else if (s == 5'd25) begin
          acc_a <= mul_res;
        end else begin
          acc_d <= (j == 2'd0) ? acc_a : add_res;
        end
      end
      ST_RCP_INIT: begin
        md  <= {acc_d[30:23] != 8'd0, acc_d[22:0]};
        ed  <= (acc_d[30:23] == 8'd0) ? 12'sd1 : 12'(acc_d[30:23]);
        inv <= (acc_d[22:0] != 23'd0) ? (acc_d | QBIT) : {acc_d[31], 31'd0};
      end
      ST_RCP_NORM: begin
        if (!md[23]) begin
          md <= {md[22:0], 1'b0};
          ed <= ed - 12'sd1;
        end else begin
          rem <= 24'd1;
          q   <= 27'd0;
          cnt <= 6'd0;
        end
      end
      ST_RCP_DIV: begin
        if (cnt != DIV_STEPS) begin
          if (rsh >= {1'b0, md}) begin
            rem <= 24'(rsh - {1'b0, md});
            q   <= {q[25:0], 1'b1};
          end else begin
            rem <= rsh[23:0];
            q   <= {q[25:0], 1'b0};
          end
          cnt <= 6'(cnt + 6'd1);
        end else begin
          inv <= pack_round(acc_d[31], qn, 12'sd255 - ed - 12'(qlz), rem != 24'd0);
        end
      end
      ST_COF: begin
        case (s)
          5'd0, 5'd3: acc_a <= rdata;
          5'd1, 5'd4, 5'd6: acc_a <= mul_res;
          5'd2: acc_b <= acc_a;
          5'd5: acc_a <= add_res;
          5'd7: acc_v <= (g == 2'd0) ? acc_a : add_res;
          default: begin
            if (emit) begin
              m_tdata <= mul_res;
              m_tuser <= 1'b0;
              m_tlast <= (k == 4'd15);
            end
          end
        endcase
      end
      ST_SING: begin
        if (emit) begin
          m_tdata <= 32'd0;
          m_tuser <= 1'b1;
          m_tlast <= (k == 4'd15);
        end
      end
      default: begin
      end
    endcase
  end

  `MCI_ASSERT_IMPLY(a_sing_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 32'd0, "singular word not zero")
  `MCI_ASSERT_IMPLY(a_div_norm, clk, rst, state == ST_RCP_DIV, md[23], "divisor not normalized")
  `MCI_ASSERT_NEXT(a_load_done, clk, rst, in_fire && count == 4'd15, state == ST_DET, "sixteenth word did not start compute")

endmodule
